@@ rtl/core/fit_policy_block_allocator_assert.svh @@
// assertion macros for the fit-policy block allocator
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FPBA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpba assertion failed");

// next-cycle implication
`define FPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpba assertion failed");

`else

`define FPBA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/fpba_pkg.sv @@
// shared types, constants and helpers for the fit-policy block allocator
package fpba_pkg;

    // store geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    // fixed field widths
    localparam int AMT_W      = 16;
    localparam int BLK_W      = 4;
    localparam int BC_W       = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CMP_W      = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

    localparam logic [BC_W-1:0] BLOCK_COUNT_RESET = 5'd16;

    typedef logic [SIZE_BITS-1:0] cap_t;
    typedef logic [CMP_W-1:0]     cmp_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [1:0] {
        FIRST_FIT = 2'd0,
        BEST_FIT  = 2'd1,
        WORST_FIT = 2'd2,
        NEXT_FIT  = 2'd3
    } policy_t;

    typedef enum logic [0:0] {
        CFG_POLICY      = 1'b0,
        CFG_BLOCK_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        MODE_LOAD    = 1'b0,
        MODE_REQUEST = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_LOADED        = 2'd0,
        ST_ALLOCATED     = 2'd1,
        ST_NOT_ALLOCATED = 2'd2
    } status_t;

    typedef struct packed {
        mode_t              mode;
        logic [BLK_W-1:0]   block_index;
        logic [AMT_W-1:0]   amount;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [BLK_W-1:0]   granted_block;
        logic [AMT_W-1:0]   leftover;
    } out_item_t;

    // capacity store access, one read and one write port
    typedef struct packed {
        logic   rd_en;
        idx_t   rd_addr;
        logic   wr_en;
        idx_t   wr_addr;
        cap_t   wr_data;
    } mem_req_t;

    function automatic cmp_t widen_cap(cap_t c);
        return CMP_W'(c);
    endfunction

    function automatic cmp_t widen_amt(logic [AMT_W-1:0] a);
        return CMP_W'(a);
    endfunction

    // loaded capacity keeps the low SIZE_BITS of the amount
    function automatic cap_t cap_from_amt(logic [AMT_W-1:0] a);
        cmp_t w;
        w = widen_amt(a);
        return w[SIZE_BITS-1:0];
    endfunction

    // capacity after taking the amount, modulo the capacity width
    function automatic cap_t cap_sub(cap_t c, logic [AMT_W-1:0] a);
        cmp_t d;
        d = widen_cap(c) - widen_amt(a);
        return d[SIZE_BITS-1:0];
    endfunction

    function automatic logic [AMT_W-1:0] amt_from_cap(cap_t c);
        cmp_t w;
        w = widen_cap(c);
        return w[AMT_W-1:0];
    endfunction

endpackage

@@ rtl/core/fit_policy_block_allocator.sv @@
// top level: configuration registers, output register and sequencer with capacity store
//
// Allocator over up to 16 block capacities with first, best, worst or next fit placement.
// A load writes its capacity at accept and then hands its result over. A request is
// accepted, then reads each block in use (block_count clamped to 16) from the capacity
// memory (one read a cycle), does the last compare in a drain state and then the
// write-back that also hands the result over. The result sits in an output
// register, so a new transaction is taken while the previous result still waits
// downstream; the write-back of a request holds until that register is free. Capacities
// read as zero after reset without a clearing pass. Configuration must be written only while
// idle; the block itself does not enforce it.
module fit_policy_block_allocator
    import fpba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    policy_t         policy_reg;
    logic [BC_W-1:0] block_count_reg;
    logic            out_valid_reg;
    out_item_t       out_data_reg;

    logic      out_free;
    logic      done;
    out_item_t result;
    mem_req_t  mem_req;
    cap_t      rd_data;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= FIRST_FIT;
            block_count_reg <= BLOCK_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_POLICY:      policy_reg      <= policy_t'(cfg_data[1:0]);
                CFG_BLOCK_COUNT: block_count_reg <= cfg_data[BC_W-1:0];
                default:         policy_reg      <= policy_reg;
            endcase
        end
    end

    // output register
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // sequencer
    fpba_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .policy      (policy_reg),
        .block_count (block_count_reg),
        .out_free    (out_free),
        .done        (done),
        .result      (result),
        .mem_req     (mem_req),
        .rd_data     (rd_data)
    );

    // capacity store
    fpba_cap_mem u_cap_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule

@@ rtl/core/fpba_cap_mem.sv @@
// capacity store: synchronous memory with registered read and per-entry valid bits
module fpba_cap_mem
    import fpba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t mem_req,
    output cap_t     rd_data
);

    cap_t                  cap_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;
    cap_t                  rd_data_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            cap_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
    end

    // valid bits, an unwritten entry reads as zero capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (mem_req.wr_en)
        begin
            valid_reg[mem_req.wr_addr] <= 1'b1;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (mem_req.rd_en)
        begin
            rd_data_reg <= valid_reg[mem_req.rd_addr] ? cap_mem[mem_req.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/fpba_ctrl.sv @@
// sequencer: loads, capacity scan with policy compare, write-back and next-fit pointer
`include "fit_policy_block_allocator_assert.svh"

module fpba_ctrl
    import fpba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    input  policy_t          policy,
    input  logic [BC_W-1:0]  block_count,
    input  logic             out_free,
    output logic             done,
    output out_item_t        result,
    output mem_req_t         mem_req,
    input  cap_t             rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE,
        S_DONE
    } state_t;

    state_t           state_reg,     state_next;
    logic [AMT_W-1:0] amount_reg,    amount_next;
    cnt_t             n_reg,         n_next;
    idx_t             addr_reg,      addr_next;
    cnt_t             left_reg,      left_next;
    logic             cmp_valid_reg, cmp_valid_next;
    idx_t             cmp_addr_reg,  cmp_addr_next;
    logic             found_reg,     found_next;
    idx_t             sel_idx_reg,   sel_idx_next;
    cap_t             sel_cap_reg,   sel_cap_next;
    idx_t             rover_reg,     rover_next;
    out_item_t        res_reg,       res_next;

    logic      accept;
    cnt_t      blocks_in_use;
    idx_t      start_addr;
    logic      store_hit;
    cnt_t      addr_inc;
    logic      cand_fits;
    logic      cand_better;
    logic      take;
    cap_t      new_cap;
    out_item_t write_result;

    // blocks searched, clamped to the store depth
    always_comb
    begin
        if (32'(block_count) > NUM_BLOCKS)
        begin
            blocks_in_use = CNT_W'(NUM_BLOCKS);
        end
        else
        begin
            blocks_in_use = CNT_W'(block_count);
        end
    end

    // next fit starts at the pointer when it is inside the blocks in use
    assign start_addr = (policy == NEXT_FIT && CNT_W'(rover_reg) < blocks_in_use) ?
                        rover_reg : '0;
    assign store_hit  = 32'(in_data.block_index) < NUM_BLOCKS;
    assign accept     = in_valid && (state_reg == S_IDLE);
    assign in_stall   = (state_reg != S_IDLE);
    assign addr_inc   = CNT_W'(addr_reg) + CNT_W'(1);

    // policy compare on the capacity coming back from the store
    always_comb
    begin
        cand_fits = widen_cap(rd_data) >= widen_amt(amount_reg);
        case (policy)
            BEST_FIT:  cand_better = rd_data < sel_cap_reg;
            WORST_FIT: cand_better = rd_data > sel_cap_reg;
            default:   cand_better = 1'b0;
        endcase
        take = cmp_valid_reg && cand_fits && (!found_reg || cand_better);
    end

    // result of a finished request
    always_comb
    begin
        new_cap = cap_sub(sel_cap_reg, amount_reg);
        if (found_reg)
        begin
            write_result.status        = ST_ALLOCATED;
            write_result.granted_block = BLK_W'(sel_idx_reg);
            write_result.leftover      = amt_from_cap(new_cap);
        end
        else
        begin
            write_result.status        = ST_NOT_ALLOCATED;
            write_result.granted_block = '0;
            write_result.leftover      = '0;
        end
    end

    // next-state and store access
    always_comb
    begin
        state_next     = state_reg;
        amount_next    = amount_reg;
        n_next         = n_reg;
        addr_next      = addr_reg;
        left_next      = left_reg;
        cmp_valid_next = 1'b0;
        cmp_addr_next  = cmp_addr_reg;
        found_next     = found_reg;
        sel_idx_next   = sel_idx_reg;
        sel_cap_next   = sel_cap_reg;
        rover_next     = rover_reg;
        res_next       = res_reg;
        mem_req        = '0;

        if (take)
        begin
            found_next   = 1'b1;
            sel_idx_next = cmp_addr_reg;
            sel_cap_next = rd_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode == MODE_LOAD)
                    begin
                        mem_req.wr_en   = store_hit;
                        mem_req.wr_addr = IDX_W'(in_data.block_index);
                        mem_req.wr_data = cap_from_amt(in_data.amount);
                        rover_next      = '0;
                        res_next        = '{status: ST_LOADED, granted_block: '0,
                                            leftover: '0};
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        amount_next = in_data.amount;
                        n_next      = blocks_in_use;
                        found_next  = 1'b0;
                        addr_next   = start_addr;
                        left_next   = blocks_in_use;
                        if (blocks_in_use == '0)
                        begin
                            res_next   = '{status: ST_NOT_ALLOCATED, granted_block: '0,
                                           leftover: '0};
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                mem_req.rd_en  = 1'b1;
                mem_req.rd_addr = addr_reg;
                cmp_valid_next = 1'b1;
                cmp_addr_next  = addr_reg;
                addr_next      = (addr_inc == n_reg) ? '0 : IDX_W'(addr_inc);
                left_next      = left_reg - CNT_W'(1);
                if (left_reg == CNT_W'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    if (found_reg)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = sel_idx_reg;
                        mem_req.wr_data = new_cap;
                        if (policy == NEXT_FIT)
                        begin
                            rover_next = sel_idx_reg;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result hand-off to the output register
    assign done   = out_free && (state_reg == S_WRITE || state_reg == S_DONE);
    assign result = (state_reg == S_WRITE) ? write_result : res_reg;

    // state and registered values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            amount_reg    <= '0;
            n_reg         <= '0;
            addr_reg      <= '0;
            left_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_addr_reg  <= '0;
            found_reg     <= 1'b0;
            sel_idx_reg   <= '0;
            sel_cap_reg   <= '0;
            rover_reg     <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            amount_reg    <= amount_next;
            n_reg         <= n_next;
            addr_reg      <= addr_next;
            left_reg      <= left_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_addr_reg  <= cmp_addr_next;
            found_reg     <= found_next;
            sel_idx_reg   <= sel_idx_next;
            sel_cap_reg   <= sel_cap_next;
            rover_reg     <= rover_next;
            res_reg       <= res_next;
        end
    end

    // write-back never collides with a scan read
    `FPBA_ASSERT_IMPLIES(a_no_rw_overlap, clk, rst_n, mem_req.wr_en, !mem_req.rd_en)
    // scan reads stay inside the blocks in use
    `FPBA_ASSERT_IMPLIES(a_scan_in_range, clk, rst_n, mem_req.rd_en, CNT_W'(mem_req.rd_addr) < n_reg)
    // a selected block always holds enough capacity
    `FPBA_ASSERT_IMPLIES(a_sel_fits, clk, rst_n, found_reg, widen_cap(sel_cap_reg) >= widen_amt(amount_reg))
    // after a result is handed off the next transaction can enter
    `FPBA_ASSERT_NEXT(a_done_then_idle, clk, rst_n, done, !in_stall)

endmodule
